### sv/ascii_status_frame_parser_defines.svh
// assertion helpers used by the top-level rtl file
`ifndef ASCII_STATUS_FRAME_PARSER_DEFINES_SVH
`define ASCII_STATUS_FRAME_PARSER_DEFINES_SVH

// property must hold on every clock while out of reset
`define ASFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold on the clock after the antecedent
`define ASFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/asfp_pkg.sv
package asfp_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 64;
  localparam int unsigned MIN_FRAME_BYTES = 10;
  localparam int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 2);

  localparam int unsigned MAX_SEQ = 65535;
  localparam int unsigned MAX_CONF = 100;
  localparam int unsigned MAX_DIGITS = 5;
  localparam int unsigned NUM_KW = 4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  localparam logic [3:0] POS_SAT = 4'd15;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_SEQ    = 6'b000010,
    PH_KEY    = 6'b000100,
    PH_CONF   = 6'b001000,
    PH_TAIL   = 6'b010000,
    PH_DEAD   = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    ST_NORMAL  = 3'd0,
    ST_YAWN    = 3'd1,
    ST_FATIGUE = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_INVALID = 3'd4
  } drv_state_e;

  typedef struct packed {
    logic [6:0]  conf;
    drv_state_e  state;
    logic [15:0] seq;
  } asfp_res_t;

  localparam logic [7:0] HDR_TEXT [5] = '{8'h44, 8'h4D, 8'h53, 8'h31, 8'h2C};

  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd4, 4'd7, 4'd7};

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{8'h4E, 8'h4F, 8'h52, 8'h4D, 8'h41, 8'h4C, 8'h00, 8'h00},
    '{8'h59, 8'h41, 8'h57, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h46, 8'h41, 8'h54, 8'h49, 8'h47, 8'h55, 8'h45, 8'h00},
    '{8'h55, 8'h4E, 8'h4B, 8'h4E, 8'h4F, 8'h57, 8'h4E, 8'h00}
  };

endpackage

### sv/ascii_status_frame_parser.sv
// ascii status frame parser
// input stream: one frame byte per word on s_axis, tlast flags the final byte
// of a frame. output stream: one result word per frame on m_axis, holding
// the sequence number, the driver state code and the confidence value.
// a word accepted on s_axis lands in an input register and is parsed on the
// following clock unless it waits; a final byte's result goes into the result
// register on m_axis. bytes are taken one per cycle unless a final byte waits.
// when the receiver stalls, the result register holds its word; bytes that
// are not final keep flowing, and a final byte waits in the input register
// until the result register is free, which then stalls s_axis.
// reset clears the parse state and the valid flags of the input register and
// the result register; the first byte after reset starts a new frame. all
// parse state also clears after every final byte.
`include "ascii_status_frame_parser_defines.svh"

module ascii_status_frame_parser import asfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // sequence_res, driver_state, confidence, zero fill
);

  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_v_q, out_v_d;
  asfp_res_t  res_q;
  asfp_res_t  core_res;
  logic       advance;

  assign advance         = in_v_q && (!in_last_q || !out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || advance;

  always_comb begin
    in_v_d = in_v_q;
    if (s_axis_tready_o) begin
      in_v_d = s_axis_tvalid_i;
    end
    out_v_d = out_v_q;
    if (advance && in_last_q) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && in_last_q) begin
      res_q <= core_res;
    end
  end

  asfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (core_res)
  );

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'd0, res_q.conf, res_q.state, res_q.seq};

  `ASFP_ASSERT_NEXT(a_result_loaded, advance && in_last_q, m_axis_tvalid_o,
    "final byte did not produce a result word")
  `ASFP_ASSERT(a_stall_only_full, !s_axis_tready_o |-> (in_v_q && in_last_q && out_v_q),
    "input stalled without a waiting final byte and a full result register")
  `ASFP_ASSERT(a_state_range, m_axis_tvalid_o |-> (m_axis_tdata_o[18:16] <= 3'd4),
    "driver state code out of range")
  `ASFP_ASSERT(a_conf_range, m_axis_tvalid_o |-> (m_axis_tdata_o[25:19] <= 7'd100),
    "confidence out of range")

endmodule

### sv/asfp_core.sv
module asfp_core import asfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output asfp_res_t  res_o
);

  logic [LEN_W-1:0] len_q, len_d;
  phase_e           phase_q, phase_d;
  logic [3:0]       pos_q, pos_d;
  logic [16:0]      acc_q, acc_d;
  logic [3:0]       cand_q, cand_d;
  logic [15:0]      seq_q, seq_d;
  logic [6:0]       conf_q, conf_d;
  drv_state_e       match_q, match_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic [7:0]       prior_q, prior_d;

  logic is_digit;
  logic found;
  logic len_ok;
  logic crlf_ok;

  always_comb begin
    len_d    = len_q;
    phase_d  = phase_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    cand_d   = cand_q;
    seq_d    = seq_q;
    conf_d   = conf_q;
    match_d  = match_q;
    hdr_ok_d = hdr_ok_q;
    found    = 1'b0;
    is_digit = byte_i inside {[8'h30:8'h39]};

    if (len_q < LEN_W'(MAX_FRAME_BYTES + 1)) begin
      len_d = len_q + LEN_W'(1);
    end

    case (phase_q)
      PH_HEADER: begin
        if (byte_i != HDR_TEXT[pos_q[2:0]]) begin
          hdr_ok_d = 1'b0;
        end
        pos_d = pos_q + 4'd1;
        if (pos_d >= 4'(MAX_DIGITS)) begin
          phase_d = PH_SEQ;
          pos_d   = 4'd0;
          acc_d   = '0;
        end
      end
      PH_SEQ, PH_CONF: begin
        if ((phase_q == PH_SEQ) && (byte_i == CHAR_COMMA)) begin
          if ((pos_q == 4'd0) || (acc_q > 17'(MAX_SEQ))) begin
            phase_d = PH_DEAD;
          end else begin
            seq_d   = acc_q[15:0];
            phase_d = PH_KEY;
            pos_d   = 4'd0;
            cand_d  = '1;
          end
        end else if ((phase_q == PH_CONF) && (byte_i == CHAR_CR)) begin
          if ((pos_q == 4'd0) || (acc_q > 17'(MAX_CONF))) begin
            phase_d = PH_DEAD;
          end else begin
            conf_d  = acc_q[6:0];
            phase_d = PH_TAIL;
            pos_d   = 4'd0;
          end
        end else if (is_digit && (pos_q < 4'(MAX_DIGITS))) begin
          acc_d = 17'((acc_q << 3) + (acc_q << 1) + {13'd0, byte_i[3:0]});
          pos_d = pos_q + 4'd1;
        end else begin
          phase_d = PH_DEAD;
        end
      end
      PH_KEY: begin
        if (byte_i == CHAR_COMMA) begin
          for (int k = 0; k < NUM_KW; k++) begin
            if (cand_q[k] && (KW_LEN[k] == pos_q) && (pos_q != 4'd0)) begin
              match_d = drv_state_e'(3'(k));
              found   = 1'b1;
            end
          end
          if (found) begin
            phase_d = PH_CONF;
            pos_d   = 4'd0;
            acc_d   = '0;
          end else begin
            phase_d = PH_DEAD;
          end
        end else begin
          for (int k = 0; k < NUM_KW; k++) begin
            if ((pos_q >= KW_LEN[k]) || (KW_TEXT[k][pos_q[2:0]] != byte_i)) begin
              cand_d[k] = 1'b0;
            end
          end
          if (cand_d == 4'd0) begin
            phase_d = PH_DEAD;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
      PH_TAIL: begin
        if (pos_q < POS_SAT) begin
          pos_d = pos_q + 4'd1;
        end
      end
      default: begin
      end
    endcase

    prior_d = last_i ? 8'd0 : byte_i;
  end

  assign len_ok  = (len_d >= LEN_W'(MIN_FRAME_BYTES)) && (len_d <= LEN_W'(MAX_FRAME_BYTES));
  assign crlf_ok = (prior_q == CHAR_CR) && (byte_i == CHAR_LF);

  always_comb begin
    res_o.seq   = '0;
    res_o.state = ST_INVALID;
    res_o.conf  = '0;
    if (len_ok && crlf_ok && hdr_ok_d) begin
      res_o.seq  = seq_d;
      res_o.conf = conf_d;
      if ((phase_d == PH_TAIL) && (pos_d == 4'd1)) begin
        res_o.state = match_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      acc_q    <= '0;
      cand_q   <= '1;
      seq_q    <= '0;
      conf_q   <= '0;
      match_q  <= ST_INVALID;
      hdr_ok_q <= 1'b1;
      prior_q  <= '0;
    end else if (step_i) begin
      if (last_i) begin
        len_q    <= '0;
        phase_q  <= PH_HEADER;
        pos_q    <= '0;
        acc_q    <= '0;
        cand_q   <= '1;
        seq_q    <= '0;
        conf_q   <= '0;
        match_q  <= ST_INVALID;
        hdr_ok_q <= 1'b1;
        prior_q  <= '0;
      end else begin
        len_q    <= len_d;
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        acc_q    <= acc_d;
        cand_q   <= cand_d;
        seq_q    <= seq_d;
        conf_q   <= conf_d;
        match_q  <= match_d;
        hdr_ok_q <= hdr_ok_d;
        prior_q  <= prior_d;
      end
    end
  end

endmodule

### tb/ascii_status_frame_parser_tb.sv
`timescale 1ns / 1ps

module ascii_status_frame_parser_tb;
  import asfp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } frame_byte_t;

  typedef enum int {
    MUT_NONE,
    MUT_HDR,
    MUT_SEQ_CHAR,
    MUT_KW_CHAR,
    MUT_KW_SHORT,
    MUT_KW_EMPTY,
    MUT_NO_COMMA,
    MUT_CONF_CHAR,
    MUT_NO_CR,
    MUT_NO_LF,
    MUT_TAIL,
    MUT_TRUNC,
    MUT_SHORT,
    MUT_COUNT
  } mut_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  localparam int unsigned DEC_SPAN [7] = '{1, 10, 100, 1000, 10000, 100000, 1000000};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = 8'h00;
  logic        in_last = 1'b0;
  logic        out_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;

  frame_byte_t frame_bytes_q [$];
  asfp_res_t   pending_status_q [$];
  logic [7:0]  frame_buf [$];
  idle_e       idle_mode = IDLE_NONE;
  int          queued_bytes = 0;
  int          mismatch_cnt = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_cnt = 0;
  frame_byte_t next_word;
  asfp_res_t   predicted;
  asfp_res_t   got;
  asfp_res_t   want;

  // parser state as the block should hold it
  int          fp_len;
  phase_e      fp_phase;
  int          fp_pos;
  int unsigned fp_acc;
  logic [3:0]  fp_cand;
  logic [15:0] fp_seq;
  logic [6:0]  fp_conf;
  drv_state_e  fp_match;
  bit          fp_hdr_ok;
  logic [7:0]  fp_prev;

  ascii_status_frame_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void clear_parse();
    fp_len = 0;
    fp_phase = PH_HEADER;
    fp_pos = 0;
    fp_acc = 0;
    fp_cand = 4'hF;
    fp_seq = '0;
    fp_conf = '0;
    fp_match = ST_INVALID;
    fp_hdr_ok = 1'b1;
    fp_prev = 8'h00;
  endfunction

  function automatic void take_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9" && fp_pos < MAX_DIGITS) begin
      fp_acc = fp_acc * 10 + int'(b - 8'h30);
      fp_pos++;
    end else begin
      fp_phase = PH_DEAD;
    end
  endfunction

  function automatic bit parse_status_byte(input logic [7:0] b, input logic is_last,
                                           output asfp_res_t res);
    bit found;
    res = '0;
    if (fp_len < MAX_FRAME_BYTES + 1) fp_len++;
    case (fp_phase)
      PH_HEADER: begin
        if (fp_pos < 5 && b != HDR_TEXT[fp_pos]) fp_hdr_ok = 1'b0;
        fp_pos++;
        if (fp_pos >= 5) begin
          fp_phase = PH_SEQ;
          fp_pos = 0;
          fp_acc = 0;
        end
      end
      PH_SEQ: begin
        if (b == CHAR_COMMA) begin
          if (fp_pos == 0 || fp_acc > MAX_SEQ) begin
            fp_phase = PH_DEAD;
          end else begin
            fp_seq = 16'(fp_acc);
            fp_phase = PH_KEY;
            fp_pos = 0;
            fp_cand = 4'hF;
          end
        end else begin
          take_digit(b);
        end
      end
      PH_KEY: begin
        if (b == CHAR_COMMA) begin
          found = 1'b0;
          for (int k = 0; k < NUM_KW; k++) begin
            if (fp_cand[k] && int'(KW_LEN[k]) == fp_pos && fp_pos != 0) begin
              fp_match = drv_state_e'(k);
              found = 1'b1;
            end
          end
          if (found) begin
            fp_phase = PH_CONF;
            fp_pos = 0;
            fp_acc = 0;
          end else begin
            fp_phase = PH_DEAD;
          end
        end else begin
          for (int k = 0; k < NUM_KW; k++) begin
            if (fp_pos >= int'(KW_LEN[k]) || KW_TEXT[k][fp_pos] != b) fp_cand[k] = 1'b0;
          end
          if (fp_cand == 4'h0) fp_phase = PH_DEAD;
          else fp_pos++;
        end
      end
      PH_CONF: begin
        if (b == CHAR_CR) begin
          if (fp_pos == 0 || fp_acc > MAX_CONF) begin
            fp_phase = PH_DEAD;
          end else begin
            fp_conf = 7'(fp_acc);
            fp_phase = PH_TAIL;
            fp_pos = 0;
          end
        end else begin
          take_digit(b);
        end
      end
      PH_TAIL: begin
        if (fp_pos < int'(POS_SAT)) fp_pos++;
      end
      default: ;
    endcase
    if (!is_last) begin
      fp_prev = b;
      return 1'b0;
    end
    res.state = ST_INVALID;
    if (fp_len >= MIN_FRAME_BYTES && fp_len <= MAX_FRAME_BYTES && fp_prev == CHAR_CR &&
        b == CHAR_LF && fp_hdr_ok) begin
      res.seq = fp_seq;
      res.conf = fp_conf;
      if (fp_phase == PH_TAIL && fp_pos == 1) res.state = fp_match;
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic bit idles_now(input bit recv_side);
    case (idle_mode)
      IDLE_SEND: return !recv_side && $urandom_range(0, 99) < 66;
      IDLE_RECV: return recv_side && $urandom_range(0, 99) < 66;
      IDLE_BOTH: return $urandom_range(0, 99) < 38;
      default:   return 1'b0;
    endcase
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && s_axis_tready_o) begin
        if (parse_status_byte(in_data, in_last, predicted)) pending_status_q.push_back(predicted);
      end
      if (!in_valid || s_axis_tready_o) begin
        if (frame_bytes_q.size() != 0 && !idles_now(1'b0)) begin
          next_word = frame_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_word.data;
          in_last  <= next_word.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      hold_cnt  <= 300;
      hold_done <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && out_ready) begin
        got = m_axis_tdata_o[$bits(asfp_res_t)-1:0];
        if (pending_status_q.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata_o);
          mismatch_cnt++;
        end else begin
          want = pending_status_q.pop_front();
          if (got.seq !== want.seq) begin
            $error("sequence_res expected %0d actual %0d", want.seq, got.seq);
            mismatch_cnt++;
          end
          if (got.state !== want.state) begin
            $error("driver_state expected %0d actual %0d", want.state, got.state);
            mismatch_cnt++;
          end
          if (got.conf !== want.conf) begin
            $error("confidence expected %0d actual %0d", want.conf, got.conf);
            mismatch_cnt++;
          end
          if (m_axis_tdata_o[31:$bits(asfp_res_t)] !== '0) begin
            $error("zero fill expected 0 actual %h", m_axis_tdata_o[31:$bits(asfp_res_t)]);
            mismatch_cnt++;
          end
        end
      end
      out_ready <= (hold_cnt == 0) && !idles_now(1'b1);
    end
  end

  task automatic push_decimal(input int unsigned v, input int d);
    string s;
    s = $sformatf("%0d", v);
    if (d > 0) begin
      for (int i = s.len(); i < d; i++) frame_buf.push_back("0");
      for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
    end
  endtask

  task automatic enqueue_frame();
    frame_byte_t w;
    for (int i = 0; i < frame_buf.size(); i++) begin
      w.data = frame_buf[i];
      w.is_last = (i == frame_buf.size() - 1);
      frame_bytes_q.push_back(w);
    end
    queued_bytes += frame_buf.size();
  endtask

  task automatic build_frame(input int kw, input int unsigned seqv, input int seqd,
                             input int unsigned confv, input int confd, input mut_e mut,
                             input int pad);
    int start;
    int idx;
    frame_buf.delete();
    for (int i = 0; i < 5; i++) frame_buf.push_back(HDR_TEXT[i]);
    if (mut == MUT_HDR) begin
      idx = $urandom_range(0, 4);
      frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    start = frame_buf.size();
    push_decimal(seqv, seqd);
    if (mut == MUT_SEQ_CHAR) frame_buf.insert($urandom_range(start, frame_buf.size()), 8'($urandom));
    frame_buf.push_back(CHAR_COMMA);
    start = frame_buf.size();
    if (mut != MUT_KW_EMPTY) begin
      for (int i = 0; i < int'(KW_LEN[kw]); i++) frame_buf.push_back(KW_TEXT[kw][i]);
    end
    if (mut == MUT_KW_CHAR) frame_buf[$urandom_range(start, frame_buf.size() - 1)] = 8'($urandom);
    if (mut == MUT_KW_SHORT) void'(frame_buf.pop_back());
    if (mut != MUT_NO_COMMA) frame_buf.push_back(CHAR_COMMA);
    start = frame_buf.size();
    push_decimal(confv, confd);
    if (mut == MUT_CONF_CHAR) frame_buf.insert($urandom_range(start, frame_buf.size()), 8'($urandom));
    if (mut != MUT_NO_CR) frame_buf.push_back(CHAR_CR);
    if (mut == MUT_TAIL) begin
      for (int i = 0; i < pad; i++) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(CHAR_CR);
    end
    if (mut != MUT_NO_LF) frame_buf.push_back(CHAR_LF);
    if (mut == MUT_TRUNC) begin
      idx = $urandom_range(1, frame_buf.size() - 1);
      while (frame_buf.size() > idx) void'(frame_buf.pop_back());
    end
    if (mut == MUT_SHORT) begin
      while (frame_buf.size() > pad) void'(frame_buf.pop_back());
      frame_buf.push_back(CHAR_CR);
      frame_buf.push_back(CHAR_LF);
    end
    enqueue_frame();
  endtask

  task automatic build_noise(input int n);
    frame_buf.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       frame_buf.push_back(CHAR_CR);
        1:       frame_buf.push_back(CHAR_LF);
        2:       frame_buf.push_back(CHAR_COMMA);
        default: frame_buf.push_back(8'($urandom));
      endcase
    end
    enqueue_frame();
  endtask

  task automatic random_frame();
    int unsigned r;
    int unsigned sv;
    int unsigned cv;
    int sd;
    int cd;
    string cs;
    mut_e m;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      build_noise($urandom_range(1, 24));
    end else begin
      sd = $urandom_range(1, 5);
      sv = $urandom_range(0, DEC_SPAN[sd] - 1);
      if (sv > MAX_SEQ && $urandom_range(0, 3) != 0) sv = $urandom_range(0, MAX_SEQ);
      case ($urandom_range(0, 19))
        0: sv = MAX_SEQ;
        1: sv = MAX_SEQ + 1;
        2: sd = 0;
        3: sd = 6;
        default: ;
      endcase
      cv = $urandom_range(0, MAX_CONF);
      cs = $sformatf("%0d", cv);
      cd = $urandom_range(cs.len(), 5);
      case ($urandom_range(0, 19))
        0: cv = MAX_CONF;
        1: begin
          cv = $urandom_range(MAX_CONF + 1, 99999);
          cd = 5;
        end
        2: cd = 0;
        3: cd = 6;
        default: ;
      endcase
      if (r < 55) m = MUT_NONE;
      else m = mut_e'($urandom_range(1, int'(MUT_COUNT) - 1));
      case (m)
        MUT_TAIL:  r = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
        MUT_SHORT: r = $urandom_range(1, 8);
        default:   r = 0;
      endcase
      build_frame($urandom_range(0, NUM_KW - 1), sv, sd, cv, cd, m, r);
    end
  endtask

  task automatic wait_drained();
    while (frame_bytes_q.size() != 0 || in_valid || pending_status_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    clear_parse();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    build_frame(0, 1, 1, 0, 1, MUT_NONE, 0);
    build_frame(1, MAX_SEQ, 5, MAX_CONF, 3, MUT_NONE, 0);
    build_frame(2, 0, 5, MAX_CONF, 5, MUT_NONE, 0);
    build_frame(3, 12345, 5, 99, 2, MUT_NONE, 0);
    build_frame(0, MAX_SEQ + 1, 5, 50, 2, MUT_NONE, 0);
    build_frame(1, 7, 1, MAX_CONF + 1, 3, MUT_NONE, 0);
    build_frame(2, 42, 6, 5, 1, MUT_NONE, 0);
    build_frame(3, 42, 2, 5, 6, MUT_NONE, 0);
    build_frame(0, 1, 0, 5, 1, MUT_NONE, 0);
    build_frame(1, 1, 1, 0, 0, MUT_NONE, 0);
    build_frame(0, 77, 2, MAX_CONF, 3, MUT_TAIL, 43);
    build_frame(0, 77, 2, MAX_CONF, 3, MUT_TAIL, 44);
    build_frame(2, 9, 1, 9, 1, MUT_TAIL, 0);
    build_frame(2, 9, 1, 9, 1, MUT_KW_SHORT, 0);
    build_frame(3, 9, 1, 9, 1, MUT_NO_CR, 0);
    build_frame(3, 9, 1, 9, 1, MUT_NO_LF, 0);
    build_frame(1, 3, 1, 3, 1, MUT_SHORT, 7);
    build_frame(1, 3, 1, 3, 1, MUT_SHORT, 8);
    build_frame(1, 3, 1, 3, 1, MUT_HDR, 0);
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h00);
    enqueue_frame();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_e'(p);
      queued_bytes = 0;
      while (queued_bytes < 50) random_frame();
      wait_drained();
    end

    // receiver stops for a long stretch while bytes keep coming
    idle_mode = IDLE_NONE;
    hold_go = 1'b1;
    for (int i = 0; i < 4; i++) begin
      build_frame($urandom_range(0, NUM_KW - 1), $urandom_range(0, MAX_SEQ), 5,
                  $urandom_range(0, MAX_CONF), 3, MUT_NONE, 0);
    end
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_status_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
